### src/wpp_pkg.sv
// wpp_pkg: shared constants, types and tables for the world point to pixel projection
// depends on nothing; used by the top level, wpp_config, wpp_rotate and wpp_project
`timescale 1ns / 1ps

package wpp_pkg;

   localparam logic signed [15:0] Q14_ONE      = 16'sd16384;
   localparam logic signed [27:0] CORDIC_GAIN  = 28'sd10188014;
   localparam int                 CORDIC_STEPS = 15;
   localparam logic [15:0]        FOCAL_RESET  = 16'd8192;
   localparam logic signed [17:0] PRINCIPAL_X  = 18'sd5120;
   localparam logic signed [17:0] PRINCIPAL_Y  = 18'sd3840;
   localparam int                 DIV_BITS     = 21;

   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_DEPTH = 2'd1,
      ST_SAT   = 2'd2
   } status_type;

   typedef enum logic [2:0] {
      REG_CAM_X   = 3'd0,
      REG_CAM_Y   = 3'd1,
      REG_CAM_Z   = 3'd2,
      REG_YAW     = 3'd3,
      REG_TILT    = 3'd4,
      REG_FOCAL_X = 3'd5,
      REG_FOCAL_Y = 3'd6
   } reg_index_type;

   typedef enum logic [1:0] {
      CFG_IDLE,
      CFG_ROTATE,
      CFG_STORE,
      CFG_PRODUCT
   } cfg_state_type;

   typedef struct packed {
      logic signed [15:0] cam_x;
      logic signed [15:0] cam_y;
      logic signed [15:0] cam_z;
      logic        [15:0] focal_x;
      logic        [15:0] focal_y;
      logic signed [15:0] yaw_sin;
      logic signed [15:0] yaw_cos;
      logic signed [15:0] tilt_sin;
      logic signed [15:0] tilt_cos;
      logic signed [29:0] ycos_tsin;
      logic signed [29:0] ysin_tsin;
      logic signed [29:0] ycos_tcos;
      logic signed [29:0] ysin_tcos;
   } cfg_type;

   // arctangent of 2^-i in binary angle units
   function automatic logic signed [15:0] atan_bau(input logic [3:0] i);
      logic signed [15:0] v;
      case (i)
         4'd0:    v = 16'sd8192;
         4'd1:    v = 16'sd4836;
         4'd2:    v = 16'sd2555;
         4'd3:    v = 16'sd1297;
         4'd4:    v = 16'sd651;
         4'd5:    v = 16'sd326;
         4'd6:    v = 16'sd163;
         4'd7:    v = 16'sd81;
         4'd8:    v = 16'sd41;
         4'd9:    v = 16'sd20;
         4'd10:   v = 16'sd10;
         4'd11:   v = 16'sd5;
         4'd12:   v = 16'sd3;
         4'd13:   v = 16'sd1;
         4'd14:   v = 16'sd1;
         default: v = 16'sd0;
      endcase
      return v;
   endfunction

endpackage

### src/wpp_req_if.sv
// wpp_req_if: input word channel, one world point per word
// no dependencies
`timescale 1ns / 1ps

interface wpp_req_if;
   logic               valid;
   logic               ready;
   logic signed [15:0] world_x;
   logic signed [15:0] world_y;
   logic signed [15:0] world_z;

   modport source (output valid, output world_x, output world_y, output world_z,
                   input ready);
   modport sink   (input valid, input world_x, input world_y, input world_z,
                   output ready);
endinterface

### src/wpp_rsp_if.sv
// wpp_rsp_if: result word channel, camera coordinates, pixel and status
// no dependencies
`timescale 1ns / 1ps

interface wpp_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [17:0] cam_frame_x;
   logic signed [17:0] cam_frame_y;
   logic signed [17:0] cam_frame_z;
   logic signed [19:0] pixel_x;
   logic signed [19:0] pixel_y;
   logic        [1:0]  status;

   modport source (output valid, output cam_frame_x, output cam_frame_y,
                   output cam_frame_z, output pixel_x, output pixel_y,
                   output status, input ready);
   modport sink   (input valid, input cam_frame_x, input cam_frame_y,
                   input cam_frame_z, input pixel_x, input pixel_y,
                   input status, output ready);
endinterface

### src/wpp_csr_if.sv
// wpp_csr_if: register write channel, index and data
// no dependencies
`timescale 1ns / 1ps

interface wpp_csr_if;
   logic        valid;
   logic        ready;
   logic [2:0]  index;
   logic [15:0] data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

### src/world_point_to_pixel_projection.sv
// world_point_to_pixel_projection: top level, register file, rotation and projection pipelines
// depends on wpp_pkg, wpp_req_if, wpp_rsp_if, wpp_csr_if, wpp_config, wpp_rotate, wpp_project
//
//   channel  dir  payload                                         handshake
//   req_bus  in   world_x, world_y, world_z                       valid / ready
//   rsp_bus  out  cam_frame_x/y/z, pixel_x/y, status              valid / ready
//   csr_bus  in   index, data                                     valid / ready
//
// one word per cycle in and out while rsp is not stalled and the config block is not busy
// the path from req to rsp is 3 rotation stages, 3 product stages, 21 divide stages and the output register
// an angle write keeps csr and req ready low while the cordic runs and the trig products are stored
// reset is synchronous; it restores the config registers, config state and valid flags, not the datapath registers
// a stalled rsp freezes the whole pipeline; nothing is dropped or repeated
`timescale 1ns / 1ps

module world_point_to_pixel_projection (
   input  logic      clock,
   input  logic      reset,
   wpp_req_if.sink   req_bus,
   wpp_rsp_if.source rsp_bus,
   wpp_csr_if.sink   csr_bus
);

   wpp_pkg::cfg_type    cfg;
   wpp_pkg::status_type status;
   logic                cfg_busy;
   logic                advance;
   logic                rot_valid;
   logic                out_valid;
   logic signed [17:0]  rot_x, rot_y, rot_z;

   assign advance       = !out_valid || rsp_bus.ready;
   assign req_bus.ready = advance && !cfg_busy;
   assign csr_bus.ready = !cfg_busy;

   wpp_config u_config (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (csr_bus.valid && csr_bus.ready),
      .wr_index (csr_bus.index),
      .wr_data  (csr_bus.data),
      .cfg      (cfg),
      .busy     (cfg_busy)
   );

   wpp_rotate u_rotate (
      .clock     (clock),
      .reset     (reset),
      .enable    (advance),
      .in_valid  (req_bus.valid && req_bus.ready),
      .world_x   (req_bus.world_x),
      .world_y   (req_bus.world_y),
      .world_z   (req_bus.world_z),
      .cfg       (cfg),
      .out_valid (rot_valid),
      .cam_x     (rot_x),
      .cam_y     (rot_y),
      .cam_z     (rot_z)
   );

   wpp_project u_project (
      .clock       (clock),
      .reset       (reset),
      .enable      (advance),
      .in_valid    (rot_valid),
      .cam_x       (rot_x),
      .cam_y       (rot_y),
      .cam_z       (rot_z),
      .focal_x     (cfg.focal_x),
      .focal_y     (cfg.focal_y),
      .out_valid   (out_valid),
      .cam_frame_x (rsp_bus.cam_frame_x),
      .cam_frame_y (rsp_bus.cam_frame_y),
      .cam_frame_z (rsp_bus.cam_frame_z),
      .pixel_x     (rsp_bus.pixel_x),
      .pixel_y     (rsp_bus.pixel_y),
      .status      (status)
   );

   assign rsp_bus.valid  = out_valid;
   assign rsp_bus.status = status;

   a_flag_zero_pixels: assert property (@(posedge clock) disable iff (reset)
      (rsp_bus.valid && status != wpp_pkg::ST_OK) |->
      (rsp_bus.pixel_x == 20'sd0 && rsp_bus.pixel_y == 20'sd0))
      else $error("flagged word carries nonzero pixels");

   a_ok_has_depth: assert property (@(posedge clock) disable iff (reset)
      (rsp_bus.valid && status == wpp_pkg::ST_OK) |-> (rsp_bus.cam_frame_z > 18'sd0))
      else $error("ok status with non-positive depth");

   a_depth_flag: assert property (@(posedge clock) disable iff (reset)
      (rsp_bus.valid && rsp_bus.cam_frame_z <= 18'sd0) |-> (status == wpp_pkg::ST_DEPTH))
      else $error("non-positive depth not flagged");

   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (csr_bus.valid && csr_bus.ready &&
       (csr_bus.index == wpp_pkg::REG_YAW || csr_bus.index == wpp_pkg::REG_TILT))
      |=> !req_bus.ready)
      else $error("word accepted while trig update runs");

endmodule

### src/wpp_config.sv
// wpp_config: register file plus iterative cordic for yaw and tilt sine and cosine
// depends on wpp_pkg
`timescale 1ns / 1ps

module wpp_config (
   input  logic             clock,
   input  logic             reset,
   input  logic             wr_en,
   input  logic [2:0]       wr_index,
   input  logic [15:0]      wr_data,
   output wpp_pkg::cfg_type cfg,
   output logic             busy
);

   wpp_pkg::cfg_state_type state_ff, state_in;

   logic signed [15:0] cam_x_ff, cam_x_in, cam_y_ff, cam_y_in, cam_z_ff, cam_z_in;
   logic        [15:0] focal_x_ff, focal_x_in, focal_y_ff, focal_y_in;
   logic signed [15:0] ysin_ff, ysin_in, ycos_ff, ycos_in;
   logic signed [15:0] tsin_ff, tsin_in, tcos_ff, tcos_in;
   logic signed [29:0] k_ycts_ff, k_ycts_in, k_ysts_ff, k_ysts_in;
   logic signed [29:0] k_yctc_ff, k_yctc_in, k_ystc_ff, k_ystc_in;

   logic signed [27:0] x_ff, x_in, y_ff, y_in;
   logic signed [15:0] z_ff, z_in;
   logic        [3:0]  step_ff, step_in;
   logic        [1:0]  quad_ff, quad_in;
   logic               zero_ff, zero_in;
   logic               tilt_sel_ff, tilt_sel_in;

   logic        [15:0] ang_u;
   logic signed [15:0] ang_r;
   logic               ang_zero;
   logic               ang_write;
   logic signed [27:0] xs, ys, cw, sw;
   logic signed [15:0] cr, sr, cq, sq;
   logic signed [31:0] p_ycts, p_ysts, p_yctc, p_ystc;

   assign ang_u     = wr_data + 16'd8192;
   assign ang_r     = $signed({2'b00, ang_u[13:0]}) - 16'sd8192;
   assign ang_zero  = (ang_u[13:0] == 14'd8192);
   assign ang_write = wr_en && (wr_index == wpp_pkg::REG_YAW || wr_index == wpp_pkg::REG_TILT);

   assign xs = x_ff >>> step_ff;
   assign ys = y_ff >>> step_ff;
   assign cw = (x_ff + 28'sd512) >>> 10;
   assign sw = (y_ff + 28'sd512) >>> 10;

   always_comb begin
      if (zero_ff) begin
         cr = wpp_pkg::Q14_ONE;
         sr = 16'sd0;
      end else begin
         if (cw > 28'sd16384)       cr = wpp_pkg::Q14_ONE;
         else if (cw < -28'sd16384) cr = -wpp_pkg::Q14_ONE;
         else                       cr = cw[15:0];
         if (sw > 28'sd16384)       sr = wpp_pkg::Q14_ONE;
         else if (sw < -28'sd16384) sr = -wpp_pkg::Q14_ONE;
         else                       sr = sw[15:0];
      end
      // quarter turns
      case (quad_ff)
         2'd1:    begin cq = -sr; sq = cr;  end
         2'd2:    begin cq = -cr; sq = -sr; end
         2'd3:    begin cq = sr;  sq = -cr; end
         default: begin cq = cr;  sq = sr;  end
      endcase
   end

   assign p_ycts = ycos_ff * tsin_ff;
   assign p_ysts = ysin_ff * tsin_ff;
   assign p_yctc = ycos_ff * tcos_ff;
   assign p_ystc = ysin_ff * tcos_ff;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         wpp_pkg::CFG_IDLE: begin
            if (ang_write) begin
               if (ang_zero) state_in = wpp_pkg::CFG_STORE;
               else          state_in = wpp_pkg::CFG_ROTATE;
            end
         end
         wpp_pkg::CFG_ROTATE: begin
            if (step_ff == 4'(wpp_pkg::CORDIC_STEPS - 1)) state_in = wpp_pkg::CFG_STORE;
         end
         wpp_pkg::CFG_STORE:   state_in = wpp_pkg::CFG_PRODUCT;
         wpp_pkg::CFG_PRODUCT: state_in = wpp_pkg::CFG_IDLE;
         default:              state_in = wpp_pkg::CFG_IDLE;
      endcase
   end

   // outputs and datapath
   always_comb begin
      cam_x_in    = cam_x_ff;
      cam_y_in    = cam_y_ff;
      cam_z_in    = cam_z_ff;
      focal_x_in  = focal_x_ff;
      focal_y_in  = focal_y_ff;
      ysin_in     = ysin_ff;
      ycos_in     = ycos_ff;
      tsin_in     = tsin_ff;
      tcos_in     = tcos_ff;
      k_ycts_in   = k_ycts_ff;
      k_ysts_in   = k_ysts_ff;
      k_yctc_in   = k_yctc_ff;
      k_ystc_in   = k_ystc_ff;
      x_in        = x_ff;
      y_in        = y_ff;
      z_in        = z_ff;
      step_in     = step_ff;
      quad_in     = quad_ff;
      zero_in     = zero_ff;
      tilt_sel_in = tilt_sel_ff;
      case (state_ff)
         wpp_pkg::CFG_IDLE: begin
            if (wr_en) begin
               case (wr_index)
                  wpp_pkg::REG_CAM_X:   cam_x_in   = wr_data;
                  wpp_pkg::REG_CAM_Y:   cam_y_in   = wr_data;
                  wpp_pkg::REG_CAM_Z:   cam_z_in   = wr_data;
                  wpp_pkg::REG_FOCAL_X: focal_x_in = wr_data;
                  wpp_pkg::REG_FOCAL_Y: focal_y_in = wr_data;
                  default: ;
               endcase
            end
            if (ang_write) begin
               tilt_sel_in = (wr_index == wpp_pkg::REG_TILT);
               x_in        = wpp_pkg::CORDIC_GAIN;
               y_in        = 28'sd0;
               z_in        = ang_r;
               step_in     = 4'd0;
               quad_in     = ang_u[15:14];
               zero_in     = ang_zero;
            end
         end
         wpp_pkg::CFG_ROTATE: begin
            if (!z_ff[15]) begin
               x_in = x_ff - ys;
               y_in = y_ff + xs;
               z_in = z_ff - wpp_pkg::atan_bau(step_ff);
            end else begin
               x_in = x_ff + ys;
               y_in = y_ff - xs;
               z_in = z_ff + wpp_pkg::atan_bau(step_ff);
            end
            step_in = step_ff + 4'd1;
         end
         wpp_pkg::CFG_STORE: begin
            if (tilt_sel_ff) begin
               tcos_in = cq;
               tsin_in = sq;
            end else begin
               ycos_in = cq;
               ysin_in = sq;
            end
         end
         wpp_pkg::CFG_PRODUCT: begin
            k_ycts_in = p_ycts[29:0];
            k_ysts_in = p_ysts[29:0];
            k_yctc_in = p_yctc[29:0];
            k_ystc_in = p_ystc[29:0];
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= wpp_pkg::CFG_IDLE;
         cam_x_ff   <= 16'sd0;
         cam_y_ff   <= 16'sd0;
         cam_z_ff   <= 16'sd0;
         focal_x_ff <= wpp_pkg::FOCAL_RESET;
         focal_y_ff <= wpp_pkg::FOCAL_RESET;
         ysin_ff    <= 16'sd0;
         ycos_ff    <= wpp_pkg::Q14_ONE;
         tsin_ff    <= 16'sd0;
         tcos_ff    <= wpp_pkg::Q14_ONE;
         k_ycts_ff  <= 30'sd0;
         k_ysts_ff  <= 30'sd0;
         k_yctc_ff  <= 30'sd268435456;
         k_ystc_ff  <= 30'sd0;
      end else begin
         state_ff   <= state_in;
         cam_x_ff   <= cam_x_in;
         cam_y_ff   <= cam_y_in;
         cam_z_ff   <= cam_z_in;
         focal_x_ff <= focal_x_in;
         focal_y_ff <= focal_y_in;
         ysin_ff    <= ysin_in;
         ycos_ff    <= ycos_in;
         tsin_ff    <= tsin_in;
         tcos_ff    <= tcos_in;
         k_ycts_ff  <= k_ycts_in;
         k_ysts_ff  <= k_ysts_in;
         k_yctc_ff  <= k_yctc_in;
         k_ystc_ff  <= k_ystc_in;
      end
   end

   always_ff @(posedge clock) begin
      x_ff        <= x_in;
      y_ff        <= y_in;
      z_ff        <= z_in;
      step_ff     <= step_in;
      quad_ff     <= quad_in;
      zero_ff     <= zero_in;
      tilt_sel_ff <= tilt_sel_in;
   end

   assign busy = (state_ff != wpp_pkg::CFG_IDLE);

   assign cfg.cam_x     = cam_x_ff;
   assign cfg.cam_y     = cam_y_ff;
   assign cfg.cam_z     = cam_z_ff;
   assign cfg.focal_x   = focal_x_ff;
   assign cfg.focal_y   = focal_y_ff;
   assign cfg.yaw_sin   = ysin_ff;
   assign cfg.yaw_cos   = ycos_ff;
   assign cfg.tilt_sin  = tsin_ff;
   assign cfg.tilt_cos  = tcos_ff;
   assign cfg.ycos_tsin = k_ycts_ff;
   assign cfg.ysin_tsin = k_ysts_ff;
   assign cfg.ycos_tcos = k_yctc_ff;
   assign cfg.ysin_tcos = k_ystc_ff;

endmodule

### src/wpp_rotate.sv
// wpp_rotate: three stage pipeline, offset, rotation products, rounded saturating sums
// depends on wpp_pkg
`timescale 1ns / 1ps

module wpp_rotate (
   input  logic               clock,
   input  logic               reset,
   input  logic               enable,
   input  logic               in_valid,
   input  logic signed [15:0] world_x,
   input  logic signed [15:0] world_y,
   input  logic signed [15:0] world_z,
   input  wpp_pkg::cfg_type   cfg,
   output logic               out_valid,
   output logic signed [17:0] cam_x,
   output logic signed [17:0] cam_y,
   output logic signed [17:0] cam_z
);

   function automatic logic signed [17:0] sat18(input logic signed [48:0] v);
      logic signed [17:0] r;
      if (v > 49'sd131071)       r = 18'sd131071;
      else if (v < -49'sd131072) r = -18'sd131072;
      else                       r = v[17:0];
      return r;
   endfunction

   logic               v1_ff, v2_ff, v3_ff;
   logic signed [16:0] dx_ff, dy_ff, dz_ff;
   logic signed [32:0] ax1_ff, ax2_ff, ay3_ff, az3_ff;
   logic signed [46:0] ay1_ff, ay2_ff, az1_ff, az2_ff;
   logic signed [17:0] cx_ff, cy_ff, cz_ff;

   logic signed [48:0] ax_sum, ay_sum, az_sum, ay_dz, az_dz;

   assign ay_dz  = 49'($signed({ay3_ff, 14'd0}));
   assign az_dz  = 49'($signed({az3_ff, 14'd0}));
   assign ax_sum = (ax1_ff - ax2_ff + 49'sd8192) >>> 14;
   assign ay_sum = (ay1_ff + ay2_ff - ay_dz + 49'sd134217728) >>> 28;
   assign az_sum = (az1_ff + az2_ff + az_dz + 49'sd134217728) >>> 28;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else if (enable) begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         dx_ff  <= {world_x[15], world_x} - {cfg.cam_x[15], cfg.cam_x};
         dy_ff  <= {world_y[15], world_y} - {cfg.cam_y[15], cfg.cam_y};
         dz_ff  <= {world_z[15], world_z} - {cfg.cam_z[15], cfg.cam_z};
         ax1_ff <= cfg.yaw_sin * dx_ff;
         ax2_ff <= cfg.yaw_cos * dy_ff;
         ay1_ff <= cfg.ycos_tsin * dx_ff;
         ay2_ff <= cfg.ysin_tsin * dy_ff;
         ay3_ff <= cfg.tilt_cos * dz_ff;
         az1_ff <= cfg.ycos_tcos * dx_ff;
         az2_ff <= cfg.ysin_tcos * dy_ff;
         az3_ff <= cfg.tilt_sin * dz_ff;
         cx_ff  <= sat18(ax_sum);
         cy_ff  <= sat18(ay_sum);
         cz_ff  <= sat18(az_sum);
      end
   end

   assign out_valid = v3_ff;
   assign cam_x     = cx_ff;
   assign cam_y     = cy_ff;
   assign cam_z     = cz_ff;

endmodule

### src/wpp_project.sv
// wpp_project: focal products, pipelined restoring divide by depth, principal point and status
// depends on wpp_pkg
`timescale 1ns / 1ps

module wpp_project (
   input  logic                clock,
   input  logic                reset,
   input  logic                enable,
   input  logic                in_valid,
   input  logic signed [17:0]  cam_x,
   input  logic signed [17:0]  cam_y,
   input  logic signed [17:0]  cam_z,
   input  logic        [15:0]  focal_x,
   input  logic        [15:0]  focal_y,
   output logic                out_valid,
   output logic signed [17:0]  cam_frame_x,
   output logic signed [17:0]  cam_frame_y,
   output logic signed [17:0]  cam_frame_z,
   output logic signed [19:0]  pixel_x,
   output logic signed [19:0]  pixel_y,
   output wpp_pkg::status_type status
);

   localparam int QW = wpp_pkg::DIV_BITS;

   typedef struct packed {
      logic [17:0]   rem;
      logic [QW-1:0] low;
      logic [QW-1:0] quo;
      logic          neg;
      logic          over;
   } lane_type;

   typedef struct packed {
      logic signed [17:0] cx;
      logic signed [17:0] cy;
      logic signed [17:0] cz;
      logic               bad;
      lane_type           lx;
      lane_type           ly;
   } div_type;

   function automatic lane_type lane_step(input lane_type l, input logic [16:0] d);
      lane_type    r;
      logic [17:0] t;
      logic        ge;
      t       = {l.rem[16:0], l.low[QW-1]};
      ge      = (t >= {1'b0, d});
      r       = l;
      r.rem   = ge ? (t - {1'b0, d}) : t;
      r.low   = {l.low[QW-2:0], 1'b0};
      r.quo   = {l.quo[QW-2:0], ge};
      return r;
   endfunction

   function automatic lane_type lane_init(input logic [33:0] mag, input logic [16:0] half,
                                          input logic [16:0] d, input logic neg);
      lane_type    r;
      logic [34:0] n;
      n      = {1'b0, mag} + {18'd0, half};
      r.rem  = {4'd0, n[34:QW]};
      r.low  = n[QW-1:0];
      r.quo  = '0;
      r.neg  = neg;
      r.over = ({3'd0, n[34:QW]} >= d);
      return r;
   endfunction

   function automatic logic signed [22:0] finish(input lane_type l,
                                                 input logic signed [17:0] pp);
      logic signed [22:0] q;
      q = $signed({2'b00, l.quo});
      if (l.neg) q = -q;
      return q + {{5{pp[17]}}, pp};
   endfunction

   // product stage
   logic               p1_v_ff, p2_v_ff;
   logic signed [34:0] nx_ff, ny_ff;
   logic signed [17:0] p1_cx_ff, p1_cy_ff, p1_cz_ff;
   // magnitude stage
   logic [33:0]        mx_ff, my_ff;
   logic               negx_ff, negy_ff, bad_ff;
   logic signed [17:0] p2_cx_ff, p2_cy_ff, p2_cz_ff;

   logic               dv_ff [0:QW];
   div_type            dd_ff [0:QW];

   logic               o_v_ff;
   logic signed [17:0] o_cx_ff, o_cy_ff, o_cz_ff;
   logic signed [19:0] o_px_ff, o_py_ff;
   wpp_pkg::status_type o_st_ff, st_in;

   logic signed [22:0] fx, fy;
   logic               rng_x, rng_y;
   logic [33:0]        mx_in, my_in;

   assign mx_in = nx_ff[34] ? 34'(-nx_ff) : nx_ff[33:0];
   assign my_in = ny_ff[34] ? 34'(-ny_ff) : ny_ff[33:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         p1_v_ff <= 1'b0;
         p2_v_ff <= 1'b0;
         dv_ff[0] <= 1'b0;
      end else if (enable) begin
         p1_v_ff <= in_valid;
         p2_v_ff <= p1_v_ff;
         dv_ff[0] <= p2_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         nx_ff    <= cam_x * $signed({1'b0, focal_x});
         ny_ff    <= cam_y * $signed({1'b0, focal_y});
         p1_cx_ff <= cam_x;
         p1_cy_ff <= cam_y;
         p1_cz_ff <= cam_z;
         mx_ff    <= mx_in;
         my_ff    <= my_in;
         negx_ff  <= nx_ff[34];
         negy_ff  <= ny_ff[34];
         bad_ff   <= p1_cz_ff[17] || (p1_cz_ff == 18'sd0);
         p2_cx_ff <= p1_cx_ff;
         p2_cy_ff <= p1_cy_ff;
         p2_cz_ff <= p1_cz_ff;
         dd_ff[0].cx  <= p2_cx_ff;
         dd_ff[0].cy  <= p2_cy_ff;
         dd_ff[0].cz  <= p2_cz_ff;
         dd_ff[0].bad <= bad_ff;
         dd_ff[0].lx  <= lane_init(mx_ff, p2_cz_ff[17:1], p2_cz_ff[16:0], negx_ff);
         dd_ff[0].ly  <= lane_init(my_ff, p2_cz_ff[17:1], p2_cz_ff[16:0], negy_ff);
      end
   end

   for (genvar g = 0; g < QW; g++) begin : g_div
      always_ff @(posedge clock) begin
         if (reset) begin
            dv_ff[g+1] <= 1'b0;
         end else if (enable) begin
            dv_ff[g+1] <= dv_ff[g];
         end
      end
      always_ff @(posedge clock) begin
         if (enable) begin
            dd_ff[g+1].cx  <= dd_ff[g].cx;
            dd_ff[g+1].cy  <= dd_ff[g].cy;
            dd_ff[g+1].cz  <= dd_ff[g].cz;
            dd_ff[g+1].bad <= dd_ff[g].bad;
            dd_ff[g+1].lx  <= lane_step(dd_ff[g].lx, dd_ff[g].cz[16:0]);
            dd_ff[g+1].ly  <= lane_step(dd_ff[g].ly, dd_ff[g].cz[16:0]);
         end
      end
   end

   assign fx    = finish(dd_ff[QW].lx, wpp_pkg::PRINCIPAL_X);
   assign fy    = finish(dd_ff[QW].ly, wpp_pkg::PRINCIPAL_Y);
   assign rng_x = (fx < -23'sd524288) || (fx > 23'sd524287);
   assign rng_y = (fy < -23'sd524288) || (fy > 23'sd524287);

   always_comb begin
      if (dd_ff[QW].bad)
         st_in = wpp_pkg::ST_DEPTH;
      else if (dd_ff[QW].lx.over || dd_ff[QW].ly.over || rng_x || rng_y)
         st_in = wpp_pkg::ST_SAT;
      else
         st_in = wpp_pkg::ST_OK;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         o_v_ff <= 1'b0;
      end else if (enable) begin
         o_v_ff <= dv_ff[QW];
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         o_cx_ff <= dd_ff[QW].cx;
         o_cy_ff <= dd_ff[QW].cy;
         o_cz_ff <= dd_ff[QW].cz;
         o_st_ff <= st_in;
         o_px_ff <= (st_in == wpp_pkg::ST_OK) ? fx[19:0] : 20'sd0;
         o_py_ff <= (st_in == wpp_pkg::ST_OK) ? fy[19:0] : 20'sd0;
      end
   end

   assign out_valid   = o_v_ff;
   assign cam_frame_x = o_cx_ff;
   assign cam_frame_y = o_cy_ff;
   assign cam_frame_z = o_cz_ff;
   assign pixel_x     = o_px_ff;
   assign pixel_y     = o_py_ff;
   assign status      = o_st_ff;

endmodule
